@@ design/keq_pkg.sv @@
// Shared constants, types and tables for the Kepler equation solver.
`timescale 1ns / 1ps
`default_nettype none
package keq_pkg;

    localparam int ANGLE_IN_W = 32;
    localparam int ECC_W      = 31;
    localparam int TOL_W      = 31;
    localparam int ITER_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // 32/(2*pi) as unsigned Q3.32
    localparam logic [34:0] TURN_SCALE = 35'd21874088818;
    localparam logic [31:0] CORDIC_X0  = 32'd652032874;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_SETUP,
        ST_CORDIC,
        ST_ROTATE,
        ST_MUL_SIN,
        ST_RESID,
        ST_CHECK,
        ST_MUL_COS,
        ST_DERIV,
        ST_DIVIDE,
        ST_UPDATE,
        ST_OUTPUT
    } t_state;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335086,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
        32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162,
        32'd81, 32'd40, 32'd20, 32'd10, 32'd5, 32'd2, 32'd1, 32'd0, 32'd0
    };

    // atan(2^-i) in units of 2^-32 turn, zero past the table
    function automatic logic [31:0] atan_turn(input logic [5:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx < 6'd32) begin
            v = ATAN_TURNS[idx[4:0]];
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/keq_if.sv @@
// Handshake channel interfaces for the Kepler equation solver.
`timescale 1ns / 1ps
`default_nettype none
interface keq_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [keq_pkg::ANGLE_IN_W-1:0] mean_anomaly;
    logic        [keq_pkg::ECC_W-1:0]      eccentricity;
    logic signed [keq_pkg::ANGLE_IN_W-1:0] initial_guess;
    modport source (output valid, mean_anomaly, eccentricity, initial_guess, input ready);
    modport sink (input valid, mean_anomaly, eccentricity, initial_guess, output ready);
endinterface

interface keq_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [keq_pkg::ANGLE_IN_W-1:0] eccentric_anomaly;
    logic                                 converged;
    logic        [keq_pkg::ITER_W-1:0]     steps_used;
    modport source (output valid, eccentric_anomaly, converged, steps_used, input ready);
    modport sink (input valid, eccentric_anomaly, converged, steps_used, output ready);
endinterface

interface keq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [keq_pkg::CFG_IDX_W-1:0]   index;
    logic [keq_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/kepler_equation_solver_unit.sv @@
// Newton solver for E - e*sin(E) = M with serial phase multiply, CORDIC and divider.
// Each residual evaluation runs the serial turn-scale multiply, then the CORDIC rotator,
// then the sine multiply and the residual check; each Newton step adds the cosine
// multiply, the derivative and the restoring divider before the update.
// One item at a time; ready only while idle. Reset restores tolerance 134 and limit 32.
`timescale 1ns / 1ps
`default_nettype none
module kepler_equation_solver_unit #(
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 28
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    keq_item_if.sink      i_item,
    keq_result_if.source  o_result,
    keq_cfg_if.sink       i_cfg
);
    import keq_pkg::*;

    localparam int W  = ANGLE_WIDTH;
    localparam int EW = (W > 32) ? W : 32;
    localparam int FW = EW + 2;
    localparam int NB = FW + 30;
    localparam int CW = $clog2(NB + 1);
    localparam int XW = 34;

    localparam logic signed [EW:0]  G_HI  = {{(EW + 2 - W){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [EW:0]  G_LO  = ~G_HI;
    localparam logic signed [W+1:0] E_HI  = {3'b000, {(W - 1){1'b1}}};
    localparam logic signed [W+1:0] E_LO  = ~E_HI;
    localparam logic signed [EW-1:0] O_HI = {{(EW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] O_LO = ~O_HI;
    localparam logic [NB-1:0]       CAP   = {{(NB - W - 1){1'b0}}, 1'b1, {W{1'b0}}};

    t_state r_state, n_state;

    logic [TOL_W-1:0]         r_tol;
    logic [ITER_W-1:0]        r_max;
    logic signed [31:0]       r_m;
    logic [ECC_W-1:0]         r_e;
    logic signed [W-1:0]      r_ea;
    logic [ITER_W-1:0]        r_steps;
    logic [CW-1:0]            r_cnt;
    logic [63:0]              r_acc;
    logic [63:0]              r_addend;
    logic [W-1:0]             r_ang_sh;
    logic [1:0]               r_quad;
    logic signed [XW-1:0]     r_x, r_y, r_z;
    logic signed [XW-1:0]     r_co, r_si;
    logic signed [65:0]       r_prod;
    logic signed [FW-1:0]     r_f;
    logic [32:0]              r_d;
    logic [32:0]              r_rem;
    logic [NB-1:0]            r_num;
    logic signed [31:0]       r_out_ea;
    logic                     r_out_conv;
    logic [ITER_W-1:0]        r_out_steps;

    // combinational datapath
    logic signed [EW:0]   g_ext;
    logic signed [W-1:0]  g_sat;
    logic [31:0]          phase, qsum, ru;
    logic [1:0]           quad;
    logic signed [XW-1:0] dx, dy, atan_v;
    logic signed [65:0]   mul_b_ext, mul_a_ext, mul_p;
    logic signed [65:0]   s_round, c_round;
    logic signed [65:0]   ec_full;
    logic signed [FW-1:0] term, ea_f, m_f;
    logic [FW-1:0]        mag;
    logic signed [34:0]   d_raw;
    logic [33:0]          rem_sh;
    logic                 qbit;
    logic [NB-1:0]        stp;
    logic signed [W+1:0]  ea_next_ext;
    logic signed [W-1:0]  ea_next;
    logic signed [EW-1:0] ea_o;
    logic signed [31:0]   ea_out;
    logic                 conv;
    logic                 finish;

    always_comb begin
        g_ext = {{(EW + 1 - 32){i_item.initial_guess[31]}}, i_item.initial_guess};
        if (g_ext > G_HI) begin
            g_sat = G_HI[W-1:0];
        end else if (g_ext < G_LO) begin
            g_sat = G_LO[W-1:0];
        end else begin
            g_sat = g_ext[W-1:0];
        end

        phase = r_acc[63:32];
        qsum  = phase + 32'h2000_0000;
        quad  = qsum[31:30];
        ru    = phase - {quad, 30'b0};

        dx     = r_y >>> r_cnt;
        dy     = r_x >>> r_cnt;
        atan_v = {2'b00, atan_turn(r_cnt[5:0])};

        mul_a_ext = {35'b0, r_e};
        mul_b_ext = (r_state == ST_MUL_COS) ? {{(66 - XW){r_co[XW-1]}}, r_co}
                                            : {{(66 - XW){r_si[XW-1]}}, r_si};
        mul_p     = mul_a_ext * mul_b_ext;

        s_round = r_prod + 66'sd8589934592;
        term    = FW'(s_round >>> 34);
        ea_f    = {{(FW - W){r_ea[W-1]}}, r_ea};
        m_f     = {{(FW - 32){r_m[31]}}, r_m};

        mag  = r_f[FW-1] ? FW'(-r_f) : FW'(r_f);
        conv = (mag <= {{(FW - TOL_W){1'b0}}, r_tol});
        finish = conv || (r_steps >= r_max);

        c_round = r_prod + 66'sd1073741824;
        ec_full = c_round >>> 31;
        d_raw   = 35'sd1073741824 - 35'(ec_full);

        rem_sh = {r_rem, r_num[NB-1]};
        qbit   = (rem_sh >= {1'b0, r_d});

        stp = (r_num > CAP) ? CAP : r_num;
        ea_next_ext = r_f[FW-1]
            ? {{2{r_ea[W-1]}}, r_ea} + $signed({1'b0, stp[W:0]})
            : {{2{r_ea[W-1]}}, r_ea} - $signed({1'b0, stp[W:0]});
        if (ea_next_ext > E_HI) begin
            ea_next = E_HI[W-1:0];
        end else if (ea_next_ext < E_LO) begin
            ea_next = E_LO[W-1:0];
        end else begin
            ea_next = ea_next_ext[W-1:0];
        end

        ea_o = {{(EW - W + 1){r_ea[W-1]}}, r_ea[W-2:0]};
        if (ea_o > O_HI) begin
            ea_out = O_HI[31:0];
        end else if (ea_o < O_LO) begin
            ea_out = O_LO[31:0];
        end else begin
            ea_out = ea_o[31:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_item.valid) n_state = ST_PHASE;
            ST_PHASE:   if (r_cnt == CW'(W - 1)) n_state = ST_SETUP;
            ST_SETUP:   n_state = ST_CORDIC;
            ST_CORDIC:  if (r_cnt == CW'(CORDIC_STAGES - 1)) n_state = ST_ROTATE;
            ST_ROTATE:  n_state = ST_MUL_SIN;
            ST_MUL_SIN: n_state = ST_RESID;
            ST_RESID:   n_state = ST_CHECK;
            ST_CHECK:   n_state = finish ? ST_OUTPUT : ST_MUL_COS;
            ST_MUL_COS: n_state = ST_DERIV;
            ST_DERIV:   n_state = ST_DIVIDE;
            ST_DIVIDE:  if (r_cnt == CW'(NB - 1)) n_state = ST_UPDATE;
            ST_UPDATE:  n_state = ST_PHASE;
            ST_OUTPUT:  if (o_result.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_item.ready               = (r_state == ST_IDLE);
        i_cfg.ready                = 1'b1;
        o_result.valid             = (r_state == ST_OUTPUT);
        o_result.eccentric_anomaly = r_out_ea;
        o_result.converged         = r_out_conv;
        o_result.steps_used        = r_out_steps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tol   <= TOL_W'(134);
            r_max   <= ITER_W'(32);
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_TOLERANCE) begin
                    r_tol <= i_cfg.data[TOL_W-1:0];
                end else if (i_cfg.index == REG_MAX_ITER) begin
                    r_max <= i_cfg.data[ITER_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_m      <= i_item.mean_anomaly;
                r_e      <= i_item.eccentricity;
                r_ea     <= g_sat;
                r_ang_sh <= g_sat;
                r_steps  <= '0;
                r_acc    <= '0;
                r_addend <= {29'b0, TURN_SCALE};
                r_cnt    <= '0;
            end
            ST_PHASE: begin
                // signed serial multiply: the sign bit carries negative weight
                if (r_ang_sh[0]) begin
                    r_acc <= (r_cnt == CW'(W - 1)) ? r_acc - r_addend : r_acc + r_addend;
                end
                r_addend <= {r_addend[62:0], 1'b0};
                r_ang_sh <= {1'b0, r_ang_sh[W-1:1]};
                r_cnt    <= r_cnt + 1'b1;
            end
            ST_SETUP: begin
                r_quad <= quad;
                r_z    <= {{(XW - 32){ru[31]}}, ru};
                r_x    <= {2'b00, CORDIC_X0};
                r_y    <= '0;
                r_cnt  <= '0;
            end
            ST_CORDIC: begin
                if (!r_z[XW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_v;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ROTATE: begin
                unique case (r_quad)
                    2'd0: begin r_co <= r_x;  r_si <= r_y;  end
                    2'd1: begin r_co <= -r_y; r_si <= r_x;  end
                    2'd2: begin r_co <= -r_x; r_si <= -r_y; end
                    default: begin r_co <= r_y; r_si <= -r_x; end
                endcase
            end
            ST_MUL_SIN, ST_MUL_COS: begin
                r_prod <= mul_p;
            end
            ST_RESID: begin
                r_f <= ea_f - term - m_f;
            end
            ST_CHECK: begin
                r_out_ea    <= ea_out;
                r_out_conv  <= conv;
                r_out_steps <= r_steps;
            end
            ST_DERIV: begin
                // clamp a vanishing derivative to one LSB
                r_d   <= (d_raw < 35'sd1) ? 33'd1 : d_raw[32:0];
                r_num <= {mag, 30'b0};
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIVIDE: begin
                r_rem <= qbit ? 33'(rem_sh - {1'b0, r_d}) : rem_sh[32:0];
                r_num <= {r_num[NB-2:0], qbit};
                r_cnt <= r_cnt + 1'b1;
            end
            ST_UPDATE: begin
                r_ea     <= ea_next;
                r_ang_sh <= ea_next;
                r_steps  <= r_steps + 1'b1;
                r_acc    <= '0;
                r_addend <= {29'b0, TURN_SCALE};
                r_cnt    <= '0;
            end
            default: begin
                // hold result for the sink
            end
        endcase
    end

endmodule
`default_nettype wire
